/* design/assert_macros.svh */
// Assertion macros shared by the blit RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Implication check, sampled on the rising clock edge, off during reset
`define BFB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");
// Condition that must never be seen on a clock edge
`define BFB_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define BFB_ASSERT(lbl, clk, rst_n, prop)
`define BFB_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

/* design/bfb_pkg.sv */
// Shared types and constants of the BMP-to-framebuffer blit.
// No dependencies; imported by every module of the block.
`default_nettype none

package bfb_pkg;

  // Parameter defaults
  localparam int DEF_MAX_IMAGE_DIM = 4095;
  localparam int DEF_SHRINK_FACTOR = 3;
  localparam int DEF_FB_INDEX_BITS = 20;

  // BMP header layout
  localparam int HDR_BYTES  = 54;
  localparam int WIDTH_OFS  = 18;
  localparam int HEIGHT_OFS = 22;
  localparam int HCNT_BITS  = 6;

  // Field widths
  localparam int BYTE_BITS     = 8;
  localparam int COORD_BITS    = 10;
  localparam int SCREEN_BITS   = 11;
  localparam int PIXEL_BITS    = 24;
  localparam int FB_OUT_BITS   = 20;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 11;

  // Register reset values
  localparam logic [SCREEN_BITS-1:0] RST_SCREEN_W = 11'd800;
  localparam logic [SCREEN_BITS-1:0] RST_SCREEN_H = 11'd480;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_DEST_X,
    REG_DEST_Y,
    REG_SCREEN_W,
    REG_SCREEN_H,
    REG_SHRINK
  } cfg_reg_t;

  // Byte position inside a BGR triple
  typedef enum logic [1:0] {
    PH_BLUE,
    PH_GREEN,
    PH_RED
  } phase_t;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [COORD_BITS-1:0]  dest_x;
    logic [COORD_BITS-1:0]  dest_y;
    logic [SCREEN_BITS-1:0] screen_w;
    logic [SCREEN_BITS-1:0] screen_h;
    logic                   shrink;
  } cfg_t;

  // Clipped pixel waiting for its index computation
  typedef struct packed {
    logic                   valid;
    logic [SCREEN_BITS-1:0] row;
    logic [SCREEN_BITS-1:0] col;
    logic [PIXEL_BITS-1:0]  pixel;
  } pix_cand_t;

endpackage

`default_nettype wire

/* design/bfb_parse.sv */
// Byte parser of the blit: header capture, row/column tracking, flip, shrink and clip.
// Depends on bfb_pkg; feeds a registered pixel candidate to bfb_index.
`default_nettype none

module bfb_parse import bfb_pkg::*; #(
  parameter int MAX_IMAGE_DIM = DEF_MAX_IMAGE_DIM,
  parameter int SHRINK_FACTOR = DEF_SHRINK_FACTOR
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [BYTE_BITS-1:0] file_byte,
  input  logic                 file_start,
  input  logic                 s2_ready,
  output pix_cand_t            cand
);

  localparam int DIM_BITS  = $clog2(MAX_IMAGE_DIM + 1);
  localparam int MOD_BITS  = $clog2(SHRINK_FACTOR);
  localparam int SUM_BITS  = DIM_BITS + 4;
  localparam int RCP_SHIFT = DIM_BITS + 3;
  localparam int RCP_BITS  = RCP_SHIFT;
  localparam int PROD_BITS = DIM_BITS + RCP_BITS;
  localparam int POS_BITS  = ((DIM_BITS > COORD_BITS) ? DIM_BITS : COORD_BITS) + 1;
  // ceil(2^shift / factor): exact quotient for every value below 2^DIM_BITS
  localparam logic [RCP_BITS-1:0] RECIP =
    RCP_BITS'(((64'd1 << RCP_SHIFT) + SHRINK_FACTOR - 1) / SHRINK_FACTOR);
  localparam logic [MOD_BITS-1:0] MOD_LAST = MOD_BITS'(SHRINK_FACTOR - 1);
  localparam logic [SUM_BITS-1:0] FACTOR   = SUM_BITS'(SHRINK_FACTOR);

  // Header state
  logic [HCNT_BITS-1:0] hcnt_r, hcnt_nxt;
  logic [23:0]          cap_r, cap_nxt;
  logic [DIM_BITS-1:0]  img_w_r, img_w_nxt;
  logic [DIM_BITS-1:0]  img_h_r, img_h_nxt;
  logic                 oversize_r, oversize_nxt;

  // Pixel data state
  logic [DIM_BITS-1:0]  row_r, row_nxt;
  logic [DIM_BITS-1:0]  col_r, col_nxt;
  logic [DIM_BITS-1:0]  col_div_r, col_div_nxt;
  logic [MOD_BITS-1:0]  col_mod_r, col_mod_nxt;
  logic [DIM_BITS-1:0]  top_r, top_nxt;
  logic [DIM_BITS-1:0]  top_div_r, top_div_nxt;
  logic [MOD_BITS-1:0]  top_mod_r, top_mod_nxt;
  phase_t               phase_r, phase_nxt;
  logic [1:0]           pad_r, pad_nxt;
  logic [BYTE_BITS-1:0] blue_r, blue_nxt;
  logic [BYTE_BITS-1:0] green_r, green_nxt;

  // Constant-reciprocal product of (height - 1)
  logic [PROD_BITS-1:0] prod_r;
  pix_cand_t            cand_r;

  logic                 in_acc;
  logic [HCNT_BITS-1:0] hcnt_cur;
  logic [23:0]          cap_cur;
  logic [1:0]           byte_sel;
  logic [31:0]          size_val;
  logic [DIM_BITS-1:0]  h_m1;
  logic [DIM_BITS-1:0]  h_quot;
  logic [SUM_BITS-1:0]  h_rem;
  logic                 data_ok;
  logic                 place;
  logic                 adv_row;
  logic                 shrink_hit;
  logic [DIM_BITS-1:0]  row_base, col_base;
  logic [POS_BITS-1:0]  scr_row, scr_col;
  logic                 on_screen;
  logic                 keep;

  assign in_tready = !cand_r.valid || s2_ready;
  assign in_acc    = in_tvalid && in_tready;
  assign cand      = cand_r;

  // Division of (height - 1) by the shrink factor, used to seed the row counters
  assign h_m1   = img_h_r - DIM_BITS'(1);
  assign h_quot = prod_r[PROD_BITS-1:RCP_SHIFT];
  assign h_rem  = SUM_BITS'(h_m1) - SUM_BITS'(h_quot) * FACTOR;

  // Start of file restarts the header from this byte
  assign hcnt_cur = file_start ? '0 : hcnt_r;
  assign cap_cur  = file_start ? '0 : cap_r;
  assign byte_sel = 2'(hcnt_cur - HCNT_BITS'(WIDTH_OFS));
  assign size_val = {file_byte, cap_cur};

  assign data_ok = !oversize_r && (img_w_r != '0) && (img_h_r != '0) && (row_r < img_h_r);

  // Screen placement of the pixel completed by this byte
  assign shrink_hit = (top_mod_r == '0) && (col_mod_r == '0) &&
                      (SUM_BITS'(top_r) + FACTOR <= SUM_BITS'(img_h_r)) &&
                      (SUM_BITS'(col_r) + FACTOR <= SUM_BITS'(img_w_r));
  assign row_base  = cfg.shrink ? top_div_r : top_r;
  assign col_base  = cfg.shrink ? col_div_r : col_r;
  assign scr_row   = POS_BITS'(row_base) + POS_BITS'(cfg.dest_y);
  assign scr_col   = POS_BITS'(col_base) + POS_BITS'(cfg.dest_x);
  assign on_screen = (scr_row < POS_BITS'(cfg.screen_h)) && (scr_col < POS_BITS'(cfg.screen_w));
  assign keep      = place && (!cfg.shrink || shrink_hit) && on_screen;

  // Next-state logic for one accepted byte
  always_comb begin
    hcnt_nxt     = hcnt_r;
    cap_nxt      = cap_r;
    img_w_nxt    = img_w_r;
    img_h_nxt    = img_h_r;
    oversize_nxt = oversize_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    col_div_nxt  = col_div_r;
    col_mod_nxt  = col_mod_r;
    top_nxt      = top_r;
    top_div_nxt  = top_div_r;
    top_mod_nxt  = top_mod_r;
    phase_nxt    = phase_r;
    pad_nxt      = pad_r;
    blue_nxt     = blue_r;
    green_nxt    = green_r;
    place        = 1'b0;
    adv_row      = 1'b0;

    if (in_acc) begin
      if (file_start || (hcnt_r < HCNT_BITS'(HDR_BYTES))) begin
        // Header byte
        hcnt_nxt = hcnt_cur + HCNT_BITS'(1);
        cap_nxt  = cap_cur;
        if (file_start) begin
          img_w_nxt    = '0;
          img_h_nxt    = '0;
          oversize_nxt = 1'b0;
          row_nxt      = '0;
          col_nxt      = '0;
          col_div_nxt  = '0;
          col_mod_nxt  = '0;
          phase_nxt    = PH_BLUE;
          pad_nxt      = '0;
        end
        if ((hcnt_cur >= HCNT_BITS'(WIDTH_OFS)) && (hcnt_cur < HCNT_BITS'(HEIGHT_OFS + 4))) begin
          if (byte_sel == 2'd3) begin
            if (size_val > 32'(MAX_IMAGE_DIM)) begin
              oversize_nxt = 1'b1;
            end else if (hcnt_cur == HCNT_BITS'(WIDTH_OFS + 3)) begin
              img_w_nxt = DIM_BITS'(size_val);
            end else begin
              img_h_nxt = DIM_BITS'(size_val);
            end
            cap_nxt = '0;
          end else begin
            cap_nxt = cap_cur | (24'(file_byte) << {byte_sel, 3'b000});
          end
        end
        // Last header byte: seed the top-down row counters
        if (hcnt_cur == HCNT_BITS'(HDR_BYTES - 1)) begin
          top_nxt     = h_m1;
          top_div_nxt = h_quot;
          top_mod_nxt = h_rem[MOD_BITS-1:0];
        end
      end else if (data_ok) begin
        if (pad_r != 2'd0) begin
          // Row padding
          pad_nxt = pad_r - 2'd1;
          adv_row = (pad_r == 2'd1);
        end else begin
          case (phase_r)
            PH_BLUE: begin
              blue_nxt  = file_byte;
              phase_nxt = PH_GREEN;
            end
            PH_GREEN: begin
              green_nxt = file_byte;
              phase_nxt = PH_RED;
            end
            PH_RED: begin
              phase_nxt = PH_BLUE;
              place     = 1'b1;
              col_nxt   = col_r + DIM_BITS'(1);
              if (col_mod_r == MOD_LAST) begin
                col_mod_nxt = '0;
                col_div_nxt = col_div_r + DIM_BITS'(1);
              end else begin
                col_mod_nxt = col_mod_r + MOD_BITS'(1);
              end
              // Row end: padding to four bytes equals width mod 4
              if (col_r == img_w_r - DIM_BITS'(1)) begin
                if (img_w_r[1:0] == 2'd0) begin
                  adv_row = 1'b1;
                end else begin
                  pad_nxt = img_w_r[1:0];
                end
              end
            end
            default: phase_nxt = PH_BLUE;
          endcase
        end

        // Move up one file row, i.e. one screen row toward the top
        if (adv_row) begin
          row_nxt     = row_r + DIM_BITS'(1);
          col_nxt     = '0;
          col_div_nxt = '0;
          col_mod_nxt = '0;
          top_nxt     = top_r - DIM_BITS'(1);
          if (top_mod_r == '0) begin
            top_mod_nxt = MOD_LAST;
            top_div_nxt = top_div_r - DIM_BITS'(1);
          end else begin
            top_mod_nxt = top_mod_r - MOD_BITS'(1);
          end
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hcnt_r       <= '0;
      cap_r        <= '0;
      img_w_r      <= '0;
      img_h_r      <= '0;
      oversize_r   <= 1'b0;
      row_r        <= '0;
      col_r        <= '0;
      col_div_r    <= '0;
      col_mod_r    <= '0;
      top_r        <= '0;
      top_div_r    <= '0;
      top_mod_r    <= '0;
      phase_r      <= PH_BLUE;
      pad_r        <= '0;
      cand_r.valid <= 1'b0;
    end else begin
      hcnt_r     <= hcnt_nxt;
      cap_r      <= cap_nxt;
      img_w_r    <= img_w_nxt;
      img_h_r    <= img_h_nxt;
      oversize_r <= oversize_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      col_div_r  <= col_div_nxt;
      col_mod_r  <= col_mod_nxt;
      top_r      <= top_nxt;
      top_div_r  <= top_div_nxt;
      top_mod_r  <= top_mod_nxt;
      phase_r    <= phase_nxt;
      pad_r      <= pad_nxt;
      if (in_tready) begin
        cand_r.valid <= in_acc && keep;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    blue_r  <= blue_nxt;
    green_r <= green_nxt;
    prod_r  <= PROD_BITS'(h_m1) * PROD_BITS'(RECIP);
    if (in_tready) begin
      cand_r.row   <= scr_row[SCREEN_BITS-1:0];
      cand_r.col   <= scr_col[SCREEN_BITS-1:0];
      cand_r.pixel <= {file_byte, green_r, blue_r};
    end
  end

endmodule

`default_nettype wire

/* design/bfb_index.sv */
// Framebuffer index stage: row * screen_width + column, wrapped, into the output register.
// Depends on bfb_pkg; takes the pixel candidate from bfb_parse.
`default_nettype none

module bfb_index import bfb_pkg::*; #(
  parameter int FB_INDEX_BITS = DEF_FB_INDEX_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [SCREEN_BITS-1:0] screen_w,
  input  pix_cand_t              cand,
  output logic                   s2_ready,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output logic [FB_OUT_BITS-1:0] fb_index,
  output logic [PIXEL_BITS-1:0]  pixel
);

  localparam int IDX_W      = 2 * SCREEN_BITS + 1;
  localparam int MASK_SHIFT = (FB_INDEX_BITS >= IDX_W) ? 0 : IDX_W - FB_INDEX_BITS;
  localparam logic [IDX_W-1:0] IDX_MASK = {IDX_W{1'b1}} >> MASK_SHIFT;

  logic                   out_valid_r;
  logic [FB_OUT_BITS-1:0] fb_index_r;
  logic [PIXEL_BITS-1:0]  pixel_r;
  logic [IDX_W-1:0]       idx_full;
  logic [IDX_W-1:0]       idx_wrap;

  // Linear index, wrapped to the framebuffer address width
  assign idx_full = IDX_W'(cand.row) * IDX_W'(screen_w) + IDX_W'(cand.col);
  assign idx_wrap = idx_full & IDX_MASK;

  assign s2_ready   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign fb_index   = fb_index_r;
  assign pixel      = pixel_r;

  // Output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= cand.valid;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (s2_ready && cand.valid) begin
      fb_index_r <= idx_wrap[FB_OUT_BITS-1:0];
      pixel_r    <= cand.pixel;
    end
  end

endmodule

`default_nettype wire

/* design/bmp_to_framebuffer_blit.sv */
// Top level of the BMP-to-framebuffer blit: configuration registers, parser and index stage.
// Depends on bfb_pkg, bfb_parse, bfb_index and assert_macros.svh.
//
// Usage:
//   The input stream carries a 24-bit BMP file one byte per transaction, in_tuser set
//   on the first byte of each file. Bytes 18..21 and 22..25 give width and height;
//   pixel data from byte 54 is read as bottom-up BGR rows padded to four bytes.
//   Each pixel that lands on screen leaves as one output transaction holding its
//   framebuffer index (row * screen_width + column) and its 24-bit 0xRRGGBB value.
//   Header bytes, padding, clipped or skipped pixels and oversize images give none.
//   One byte is taken every cycle while in_tready is high; a pixel completed by its red
//   byte goes through the candidate register, then the output register, to out_tvalid.
//   If the receiver stalls, the output register and the candidate register fill;
//   in_tready then drops until the output transaction completes.
//   Configuration is written through cfg_we/cfg_addr/cfg_wdata while the stream is
//   idle. Synchronous active-low reset clears the registers to their defaults
//   (screen 800 x 480, origin 0, full size) and restarts header parsing.
`default_nettype none
`include "assert_macros.svh"

module bmp_to_framebuffer_blit import bfb_pkg::*; #(
  parameter int MAX_IMAGE_DIM = DEF_MAX_IMAGE_DIM,
  parameter int SHRINK_FACTOR = DEF_SHRINK_FACTOR,
  parameter int FB_INDEX_BITS = DEF_FB_INDEX_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Input stream
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [7:0]               in_tdata,   // [7:0] file_byte
  input  logic                     in_tuser,   // [0] file_start
  // Result stream
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [47:0]              out_tdata,  // [19:0] fb_index, [43:20] pixel, zero fill
  // Configuration write port
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  cfg_t                   cfg_r;
  pix_cand_t              cand;
  logic                   s2_ready;
  logic [FB_OUT_BITS-1:0] fb_index;
  logic [PIXEL_BITS-1:0]  pixel;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dest_x   <= '0;
      cfg_r.dest_y   <= '0;
      cfg_r.screen_w <= RST_SCREEN_W;
      cfg_r.screen_h <= RST_SCREEN_H;
      cfg_r.shrink   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_DEST_X:   cfg_r.dest_x   <= cfg_wdata[COORD_BITS-1:0];
        REG_DEST_Y:   cfg_r.dest_y   <= cfg_wdata[COORD_BITS-1:0];
        REG_SCREEN_W: cfg_r.screen_w <= cfg_wdata[SCREEN_BITS-1:0];
        REG_SCREEN_H: cfg_r.screen_h <= cfg_wdata[SCREEN_BITS-1:0];
        REG_SHRINK:   cfg_r.shrink   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  bfb_parse #(
    .MAX_IMAGE_DIM (MAX_IMAGE_DIM),
    .SHRINK_FACTOR (SHRINK_FACTOR)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .file_byte  (in_tdata),
    .file_start (in_tuser),
    .s2_ready   (s2_ready),
    .cand       (cand)
  );

  bfb_index #(
    .FB_INDEX_BITS (FB_INDEX_BITS)
  ) u_index (
    .clk        (clk),
    .rst_n      (rst_n),
    .screen_w   (cfg_r.screen_w),
    .cand       (cand),
    .s2_ready   (s2_ready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .fb_index   (fb_index),
    .pixel      (pixel)
  );

  assign out_tdata = {4'b0000, pixel, fb_index};

  // Back-pressure only when both pipeline registers hold a pixel and the sink stalls
  `BFB_ASSERT(a_ready_only_when_full, clk, rst_n, !in_tready |-> (cand.valid && out_tvalid && !out_tready))
  // A pending candidate moves into the output register when that register frees up
  `BFB_ASSERT(a_cand_moves_out, clk, rst_n, (cand.valid && (!out_tvalid || out_tready)) |=> out_tvalid)
  // No candidate appears without an accepted byte
  `BFB_ASSERT(a_no_phantom_cand, clk, rst_n, (in_tready && !in_tvalid) |=> !cand.valid)

endmodule

`default_nettype wire
